>>> hdl/brl_pkg.sv
// Shared constants and types of the block RMS level engine.
package brl_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int MAX_SAMPLES = 1024;
   localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
   localparam int COUNT_OUT_W = 11;
   localparam int LEVEL_W     = 15;
   localparam int LEVEL_MAX   = (1 << LEVEL_W) - 1;

   // A square of a full-scale sample is at most 2^30.
   localparam int PROD_W      = 2 * SAMPLE_W - 1;
   localparam int SUM_W       = PROD_W + $clog2(MAX_SAMPLES);
   localparam int ROOT_STEPS  = (PROD_W + 1) / 2;
   localparam int ROOT_W      = ROOT_STEPS;
   localparam int WORK_W      = (SUM_W > 2 * ROOT_STEPS) ? SUM_W : 2 * ROOT_STEPS;
   localparam int SUB_W       = (COUNT_W + 1 > ROOT_W + 3) ? COUNT_W + 1 : ROOT_W + 3;
   localparam int STEP_W      = $clog2(SUM_W);

   typedef struct packed {
      logic [LEVEL_W-1:0]     rms_level;
      logic [COUNT_OUT_W-1:0] sample_count;
      logic                   overflowed;
   } brl_result_type;

   typedef struct packed {
      logic             ge;
      logic [SUB_W-1:0] diff;
   } brl_sub_result_type;

endpackage

>>> hdl/brl_if.sv
// Sample and result channel interfaces of the block RMS level engine.
interface brl_req_if;
   import brl_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface brl_rsp_if;
   import brl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [LEVEL_W-1:0]     rms_level;
   logic [COUNT_OUT_W-1:0] sample_count;
   logic                   overflowed;

   modport source (output valid, output rms_level, output sample_count, output overflowed,
                   input ready);
   modport sink (input valid, input rms_level, input sample_count, input overflowed,
                 output ready);
endinterface

>>> hdl/block_rms_level_top.sv
// Top level of the block RMS level engine with its output register.
//
//   channel   dir   payload                                   transfer
//   req_in    in    sample (s16), last (1)                    valid && ready
//   rsp_out   out   rms_level (15), sample_count (11),        valid && ready
//                   overflowed (1)
//
// Each sample is taken, squared and accumulated in turn; ready is low meanwhile.
// A sample marked last then goes through restoring division (one quotient bit per
// cycle) and square root (one root bit per cycle), both on the one shared
// subtractor, then a deliver step that hands the result to the output register.
// Reset is synchronous: sum, count, overflow flag, sequencer and output valid clear.
// A stalled result holds in the output register; samples are still taken while it
// waits, and the sequencer holds the next result until the register frees up.
module block_rms_level_top (
   input logic        clock,
   input logic        reset,
   brl_req_if.sink    req_in,
   brl_rsp_if.source  rsp_out
);
   import brl_pkg::*;

   logic           slot_free;
   logic           result_valid;
   brl_result_type result;

   logic           rsp_valid_ff, rsp_valid_in;
   brl_result_type rsp_data_ff, rsp_data_in;

   // The slot frees when it is empty or its result transfers this cycle.
   assign slot_free = !rsp_valid_ff || rsp_out.ready;

   brl_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_in.valid),
      .req_ready    (req_in.ready),
      .req_sample   (req_in.sample),
      .req_last     (req_in.last),
      .slot_free    (slot_free),
      .result_valid (result_valid),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (result_valid && slot_free) begin
         // Load the new result, possibly in the same cycle the old one leaves.
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_out.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_out.valid        = rsp_valid_ff;
   assign rsp_out.rms_level    = rsp_data_ff.rms_level;
   assign rsp_out.sample_count = rsp_data_ff.sample_count;
   assign rsp_out.overflowed   = rsp_data_ff.overflowed;

endmodule

>>> hdl/brl_subtract.sv
// Shared trial subtractor: difference and no-borrow flag.
module brl_subtract (
   input  logic [brl_pkg::SUB_W-1:0]  minuend,
   input  logic [brl_pkg::SUB_W-1:0]  subtrahend,
   output brl_pkg::brl_sub_result_type result
);
   import brl_pkg::*;

   logic [SUB_W:0] wide_diff;

   assign wide_diff   = {1'b0, minuend} - {1'b0, subtrahend};
   assign result.diff = wide_diff[SUB_W-1:0];
   assign result.ge   = !wide_diff[SUB_W];
endmodule

>>> hdl/brl_engine.sv
// Sequencer: square and accumulate, then divide and root on the shared subtractor.
module brl_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [brl_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               req_last,
   input  logic                               slot_free,
   output logic                               result_valid,
   output brl_pkg::brl_result_type            result
);
   import brl_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SQUARE  = 6'b000010,
      ST_ACCUM   = 6'b000100,
      ST_DIVIDE  = 6'b001000,
      ST_ROOT    = 6'b010000,
      ST_DELIVER = 6'b100000
   } brl_state_type;

   brl_state_type              state_ff, state_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       last_ff, last_in;
   logic [PROD_W-1:0]          product_ff, product_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       excess_ff, excess_in;
   logic [WORK_W-1:0]          work_ff, work_in;
   logic [SUB_W-1:0]           rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [STEP_W-1:0]          step_ff, step_in;

   logic signed [2*SAMPLE_W-1:0] square_full;
   logic                         block_full;
   logic [SUM_W-1:0]             sum_next;
   logic [SUB_W-1:0]             div_minuend;
   logic [SUB_W-1:0]             root_minuend;
   logic [SUB_W-1:0]             root_trial;
   logic [SUB_W-1:0]             sub_a;
   logic [SUB_W-1:0]             sub_b;
   brl_sub_result_type           sub_res;

   assign square_full = sample_ff * sample_ff;
   assign block_full  = (count_ff >= COUNT_W'(MAX_SAMPLES));
   assign sum_next    = block_full ? sum_ff : sum_ff + SUM_W'(product_ff);

   // Divide: shift in the next dividend bit; root: shift in the next pair of bits.
   assign div_minuend  = {rem_ff[SUB_W-2:0], work_ff[WORK_W-1]};
   assign root_minuend = {rem_ff[SUB_W-3:0], work_ff[2*ROOT_STEPS-1 -: 2]};
   assign root_trial   = SUB_W'({root_ff, 2'b01});

   assign sub_a = (state_ff == ST_DIVIDE) ? div_minuend : root_minuend;
   assign sub_b = (state_ff == ST_DIVIDE) ? SUB_W'(count_ff) : root_trial;

   brl_subtract u_subtract (
      .minuend    (sub_a),
      .subtrahend (sub_b),
      .result     (sub_res)
   );

   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      last_in    = last_ff;
      product_in = product_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      excess_in  = excess_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      step_in    = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               last_in   = req_last;
               state_in  = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            product_in = square_full[PROD_W-1:0];
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            sum_in = sum_next;
            if (block_full) begin
               excess_in = 1'b1;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (last_ff) begin
               work_in  = WORK_W'(sum_next);
               rem_in   = '0;
               step_in  = STEP_W'(SUM_W - 1);
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            // Quotient bits shift in at the low end as dividend bits leave the top.
            work_in = {work_ff[WORK_W-2:0], sub_res.ge};
            rem_in  = sub_res.ge ? sub_res.diff : div_minuend;
            if (step_ff == '0) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_STEPS - 1);
               state_in = ST_ROOT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_ROOT: begin
            work_in = {work_ff[WORK_W-3:0], 2'b00};
            rem_in  = sub_res.ge ? sub_res.diff : root_minuend;
            root_in = {root_ff[ROOT_W-2:0], sub_res.ge};
            if (step_ff == '0) begin
               state_in = ST_DELIVER;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DELIVER: begin
            if (slot_free) begin
               sum_in    = '0;
               count_in  = '0;
               excess_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         count_ff  <= '0;
         excess_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         excess_ff <= excess_in;
      end
      sample_ff  <= sample_in;
      last_ff    <= last_in;
      product_ff <= product_in;
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      step_ff    <= step_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign result_valid = (state_ff == ST_DELIVER);

   assign result.rms_level    = (root_ff > ROOT_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                               : root_ff[LEVEL_W-1:0];
   assign result.sample_count = COUNT_OUT_W'(count_ff);
   assign result.overflowed   = excess_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SAMPLES))
      else $error("sample count beyond block size");

   a_excess_full: assert property (@(posedge clock) disable iff (reset)
      excess_ff |-> (count_ff == COUNT_W'(MAX_SAMPLES)))
      else $error("excess flag set before block full");

   a_divide_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && step_ff == '0) |=> (state_ff == ST_ROOT))
      else $error("divide did not hand over to root");

   a_deliver_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELIVER) |-> (count_ff != '0))
      else $error("result with empty block");

   a_deliver_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DELIVER && !slot_free) |=> (state_ff == ST_DELIVER && $stable(root_ff)))
      else $error("result lost while output slot full");

endmodule

>>> tb/tb_block_rms_level_top.sv
// Testbench for block_rms_level_top: random sample blocks, RMS predictor, result checks.
module tb_block_rms_level_top;
   timeunit 1ns;
   timeprecision 1ps;

   import brl_pkg::*;

   // Cycles without any transfer on either channel before the run is declared hung.
   // The slowest legal stretch is a last sample: its divide and root, plus random
   // sender gaps and receiver stalls.
   localparam int HANG_LIMIT   = 4000;
   // Cycles to sit idle after the last result, well past the divide and root latency.
   localparam int SETTLE_CYCLES = 120;
   localparam int RANDOM_ITEMS  = 1250;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      bit                         drain;   // hold off until every result is back
   } sample_item_type;

   logic clock;
   logic reset;

   brl_req_if req_bus ();
   brl_rsp_if rsp_bus ();

   block_rms_level_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus)
   );

   sample_item_type pending_samples[$];
   brl_result_type  expected_levels[$];

   // Predictor state: one block's running sum of squares, its count and overflow flag.
   logic [SUM_W-1:0]   square_total;
   logic [COUNT_W-1:0] taken_count;
   logic               block_overrun;

   int results_due;     // owned by the driver
   int results_seen;    // owned by the monitor, updated with nonblocking assignments
   int mismatches;
   int idle_cycles;
   int req_wait;
   int rsp_stall;
   bit req_burst;
   bit rsp_burst;

   always #2 clock = ~clock;

   // Floor integer square root by setting one root bit at a time, top bit first.
   function automatic longint unsigned isqrt_floor(input longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Fold one transferred sample into the predicted block; on last, queue its RMS level.
   task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] s, input logic l);
      longint         wide;
      longint unsigned mean;
      longint unsigned root;
      brl_result_type level;
      wide = s;
      if (taken_count < MAX_SAMPLES) begin
         square_total = square_total + SUM_W'(wide * wide);
         taken_count  = taken_count + 1'b1;
      end else begin
         block_overrun = 1'b1;
      end
      if (l) begin
         mean = (taken_count != 0) ? 64'(square_total) / 64'(taken_count) : 64'd0;
         root = isqrt_floor(mean);
         if (root > LEVEL_MAX) begin
            root = LEVEL_MAX;
         end
         level.rms_level    = LEVEL_W'(root);
         level.sample_count = COUNT_OUT_W'(taken_count);
         level.overflowed   = block_overrun;
         expected_levels.push_back(level);
         results_due   = results_due + 1;
         square_total  = '0;
         taken_count   = '0;
         block_overrun = 1'b0;
      end
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_W-1:0] s, input logic l,
                               input bit d = 1'b0);
      sample_item_type item;
      item.sample = s;
      item.last   = l;
      item.drain  = d;
      pending_samples.push_back(item);
   endtask

   // Draw a sample from one of several shapes: full range, near zero, rails, high magnitude.
   function automatic logic signed [SAMPLE_W-1:0] draw_sample();
      logic [SAMPLE_W-1:0] bits;
      case ($urandom_range(0, 3))
         0: bits = SAMPLE_W'($urandom);
         1: bits = SAMPLE_W'($urandom_range(0, 16) - 8);
         2: bits = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: begin
            bits = SAMPLE_W'($urandom_range(30000, 32767));
            if ($urandom_range(0, 1)) begin
               bits = -bits;
            end
         end
      endcase
      return bits;
   endfunction

   // Driver: present one pending sample at a time, with a random gap after each transfer.
   always @(posedge clock) begin : sample_driver
      sample_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            accumulate_sample(req_bus.sample, req_bus.last);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the current transfer until the block takes it
         end else if (req_wait != 0) begin
            req_wait = req_wait - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_samples.size() != 0 &&
                      !(pending_samples[0].drain && results_due != results_seen)) begin
            next_item = pending_samples.pop_front();
            req_bus.valid  <= 1'b1;
            req_bus.sample <= next_item.sample;
            req_bus.last   <= next_item.last;
            if ($urandom_range(0, 39) == 0) begin
               req_burst = ~req_burst;
            end
            req_wait = req_burst ? 0 : $urandom_range(0, 5);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each result transfer with the oldest predicted level, then stall.
   always @(posedge clock) begin : level_monitor
      brl_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen <= results_seen + 1;
            if (expected_levels.size() == 0) begin
               mismatches = mismatches + 1;
               $display("%0t: unexpected result rms_level %0d sample_count %0d overflowed %0d",
                        $realtime, rsp_bus.rms_level, rsp_bus.sample_count,
                        rsp_bus.overflowed);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_bus.rms_level !== want.rms_level) begin
                  mismatches = mismatches + 1;
                  $display("%0t: rms_level expected %0d actual %0d",
                           $realtime, want.rms_level, rsp_bus.rms_level);
               end
               if (rsp_bus.sample_count !== want.sample_count) begin
                  mismatches = mismatches + 1;
                  $display("%0t: sample_count expected %0d actual %0d",
                           $realtime, want.sample_count, rsp_bus.sample_count);
               end
               if (rsp_bus.overflowed !== want.overflowed) begin
                  mismatches = mismatches + 1;
                  $display("%0t: overflowed expected %0d actual %0d",
                           $realtime, want.overflowed, rsp_bus.overflowed);
               end
            end
            if ($urandom_range(0, 9) == 0) begin
               rsp_burst = ~rsp_burst;
            end
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 5);
         end
         if (rsp_stall != 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: drop the run once neither channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("block_rms_level_top verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int issued;
      int run_len;
      clock         = 1'b0;
      reset         = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      req_bus.last   = 1'b0;
      rsp_bus.ready  = 1'b0;
      square_total  = '0;
      taken_count   = '0;
      block_overrun = 1'b0;
      results_due   = 0;
      results_seen  = 0;
      mismatches    = 0;
      idle_cycles   = 0;
      req_wait      = 0;
      rsp_stall     = 0;
      req_burst     = 1'b0;
      rsp_burst     = 1'b0;

      // Directed: single-sample blocks at the rails and near zero. A lone negative
      // full-scale sample gives a mean of 2^30, whose root 32768 must saturate.
      queue_sample(-16'sd32768, 1'b1);
      queue_sample(16'sd32767, 1'b1);
      queue_sample(16'sd0, 1'b1);
      queue_sample(16'sd1, 1'b1);
      queue_sample(-16'sd1, 1'b1);
      // Mixed rails and zero in one block.
      queue_sample(-16'sd32768, 1'b0);
      queue_sample(16'sd32767, 1'b0);
      queue_sample(16'sd0, 1'b0);
      queue_sample(-16'sd1, 1'b1);
      // Truncating mean: (9 + 16) / 2 = 12, root 3.
      queue_sample(16'sd3, 1'b0);
      queue_sample(16'sd4, 1'b1);
      // Uneven mean with a negative middle sample.
      queue_sample(16'sd100, 1'b0);
      queue_sample(-16'sd100, 1'b0);
      queue_sample(16'sd7, 1'b1);
      // All-negative full-scale pair: saturation again with a count of two.
      queue_sample(-16'sd32768, 1'b0);
      queue_sample(-16'sd32768, 1'b1);

      // Random: short blocks of varied content; in the middle one oversize block whose
      // first MAX_SAMPLES samples sit at the rails (the widest sum) and whose tail,
      // last sample included, arrives with the block full and must be dropped.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if (issued >= RANDOM_ITEMS / 8 && issued < RANDOM_ITEMS / 8 + 12) begin
            run_len = MAX_SAMPLES + $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++) begin
               if (k < MAX_SAMPLES) begin
                  queue_sample($urandom_range(0, 3) == 0 ? 16'sh7FFF : 16'sh8000, 1'b0,
                               k == 0);
               end else begin
                  queue_sample(draw_sample(), k == run_len - 1);
               end
            end
         end else begin
            run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len; k++) begin
               queue_sample(draw_sample(), k == run_len - 1, issued == 0 && k == 0);
            end
         end
         issued = issued + run_len;
      end
      // Drain once more before the final sample goes out.
      pending_samples[pending_samples.size() - 1].drain = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Advance until every sample is taken and every predicted level has come back.
      do @(posedge clock);
      while (pending_samples.size() != 0 || req_bus.valid);
      do @(posedge clock);
      while (results_due != results_seen);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_levels.size() == 0) begin
         $display("block_rms_level_top verification clean");
      end else begin
         $display("block_rms_level_top verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/brl_pkg.sv
hdl/brl_if.sv
hdl/brl_subtract.sv
hdl/brl_engine.sv
hdl/block_rms_level_top.sv
tb/tb_block_rms_level_top.sv
